// File: design/ssa_pkg.sv
// shared types and constants of the slab slot allocator
// no dependencies; compiled before every other file of the block

package ssa_pkg;

   // payload widths of the channels
   localparam int CMD_W      = 2;
   localparam int SLOT_IDX_W = 10;
   localparam int OFFSET_W   = 22;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;

   // configuration registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int SPC_W      = 11;
   localparam int ISZ_W      = 13;
   localparam int ALG_W      = 4;
   localparam int STRIDE_W   = 13;

   localparam logic [SPC_W-1:0] SPC_RESET   = 11'd64;
   localparam logic [ISZ_W-1:0] ISZ_RESET   = 13'd8;
   localparam logic [ALG_W-1:0] ALG_RESET   = 4'd4;
   localparam logic [ALG_W-1:0] MAX_ALIGN_LOG2 = 4'd12;
   localparam logic [ISZ_W-1:0] MAX_ITEM_BYTES = 13'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_DESTROY = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 2'd0,
      ST_OOM            = 2'd1,
      ST_NOT_OWNED      = 2'd2,
      ST_DESTROYED_LIVE = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOTS_PER_CHUNK = 2'd0,
      CSR_ITEM_SIZE       = 2'd1,
      CSR_ALIGN_LOG2      = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_GROW
   } state_type;

   // effective configuration seen by the control logic
   typedef struct packed {
      logic [SPC_W-1:0]    chunk;
      logic [STRIDE_W-1:0] stride;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot;
      logic [OFFSET_W-1:0]   byte_offset;
      status_type            status;
      logic [COUNT_W-1:0]    live_count;
      logic [COUNT_W-1:0]    capacity;
   } res_type;

endpackage

// File: design/ssa_if.sv
// channel interfaces of the slab slot allocator: request, response, csr write
// depends on ssa_pkg

interface ssa_req_if;
   import ssa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic                  is_null;
   modport source (output valid, command, slot_index, is_null, input ready);
   modport sink   (input valid, command, slot_index, is_null, output ready);
endinterface

interface ssa_rsp_if;
   import ssa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [SLOT_IDX_W-1:0] slot;
   logic [OFFSET_W-1:0]   byte_offset;
   logic [STATUS_W-1:0]   status;
   logic [COUNT_W-1:0]    live_count;
   logic [COUNT_W-1:0]    capacity;
   modport source (output valid, slot, byte_offset, status, live_count, capacity,
                   input ready);
   modport sink   (input valid, slot, byte_offset, status, live_count, capacity,
                   output ready);
endinterface

interface ssa_csr_if;
   import ssa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ssa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module ssa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: design/ssa_cfg.sv
// configuration registers of the slab slot allocator, chunk clamp and stride
// depends on ssa_pkg and ssa_csr_if

module ssa_cfg #(
   parameter int MIN_CHUNK_SLOTS = 8,
   parameter int POINTER_BYTES   = 8
) (
   input  logic             clock,
   input  logic             reset,
   ssa_csr_if.sink          csr_ch,
   output ssa_pkg::cfg_type cfg
);
   import ssa_pkg::*;

   logic [SPC_W-1:0]    spc_ff, spc_in;
   logic [ISZ_W-1:0]    isz_ff, isz_in;
   logic [ALG_W-1:0]    alg_ff, alg_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   logic [ALG_W-1:0]    lg;
   logic [ISZ_W-1:0]    sz;
   logic [ISZ_W:0]      amask;
   logic [ISZ_W:0]      rounded;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      spc_in = spc_ff;
      isz_in = isz_ff;
      alg_in = alg_ff;
      if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_SLOTS_PER_CHUNK: spc_in = csr_ch.data[SPC_W-1:0];
            CSR_ITEM_SIZE:       isz_in = csr_ch.data[ISZ_W-1:0];
            CSR_ALIGN_LOG2:      alg_in = csr_ch.data[ALG_W-1:0];
            default: ;
         endcase
      end
   end

   // stride: size clamped, rounded up to the alignment, at least one pointer
   always_comb begin
      lg      = (alg_ff > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : alg_ff;
      amask   = ((ISZ_W+1)'(1) << lg) - (ISZ_W+1)'(1);
      if (isz_ff == '0) begin
         sz = ISZ_W'(1);
      end else if (isz_ff > MAX_ITEM_BYTES) begin
         sz = MAX_ITEM_BYTES;
      end else begin
         sz = isz_ff;
      end
      rounded = ((ISZ_W+1)'(sz) + amask) & ~amask;
      if (rounded < (ISZ_W+1)'(POINTER_BYTES)) begin
         stride_in = STRIDE_W'(POINTER_BYTES);
      end else begin
         stride_in = rounded[STRIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff <= SPC_RESET;
         isz_ff <= ISZ_RESET;
         alg_ff <= ALG_RESET;
      end else begin
         spc_ff <= spc_in;
         isz_ff <= isz_in;
         alg_ff <= alg_in;
      end
   end

   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
   end

   assign cfg.chunk  = (spc_ff < SPC_W'(MIN_CHUNK_SLOTS)) ? SPC_W'(MIN_CHUNK_SLOTS) : spc_ff;
   assign cfg.stride = stride_ff;

endmodule

// File: design/slab_slot_allocator.sv
// slab slot allocator top level: free-list control, link memory, result buffer
// depends on ssa_pkg, ssa_if, ssa_ram and ssa_cfg
//
// usage
// - req_ch carries one command per transaction: alloc, free (slot_index, is_null)
//   or destroy; rsp_ch returns exactly one result per request, in order
// - csr_ch writes slots_per_chunk, item_size and align_log2; write only while idle
// - free, destroy and the unused code: result goes to the output register, or to the
//   hold register while rsp_ch stalls; one transaction per cycle while req_ch.ready stays high
// - alloc from a non-empty list: passes through the pop state, waiting for the link
//   memory read of the head entry (registered read) before the head can move
// - alloc that grows the pool: one link written per cycle in the grow state
// - alloc with the pool exhausted: out_of_memory result issued at acceptance, no growth
// - one command is in flight at a time, so memory accesses never overlap
// - reset empties the pool and loads the csr defaults (64, 8, 4); the link
//   memory is not swept, every entry is written before it is read
// - receiver stall: one result waits in the output register and one more in a
//   hold register; req_ch.ready drops while the hold register is full or outside idle

module slab_slot_allocator #(
   parameter int MAX_SLOTS       = 1024,
   parameter int MIN_CHUNK_SLOTS = 8,
   parameter int POINTER_BYTES   = 8
) (
   input  logic    clock,
   input  logic    reset,
   ssa_req_if.sink   req_ch,
   ssa_rsp_if.source rsp_ch,
   ssa_csr_if.sink   csr_ch
);
   import ssa_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SUM_W  = ((CNT_W > SPC_W) ? CNT_W : SPC_W) + 1;
   localparam int CMP_W  = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;
   localparam int PROD_W = SLOT_W + STRIDE_W;

   cfg_type cfg;

   // control state
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [SLOT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [SLOT_W-1:0] top_ff, top_in;

   // result buffering
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff, rsp_res_in;
   logic    hold_valid_ff, hold_valid_in;
   res_type hold_res_ff, hold_res_in;
   logic    res_fire;
   res_type res;
   logic    out_free;

   // link memory ports
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [SLOT_W-1:0] mem_wdata;
   logic [SLOT_W-1:0] mem_rdata;

   logic              accept;
   logic [SUM_W-1:0]  grow_sum;
   logic              grow_oom;
   logic              not_owned;
   logic [SLOT_W-1:0] grow_link;
   logic [SLOT_W-1:0] mul_a;
   logic [PROD_W-1:0] prod;

   ssa_cfg #(
      .MIN_CHUNK_SLOTS (MIN_CHUNK_SLOTS),
      .POINTER_BYTES   (POINTER_BYTES)
   ) u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // head entry is read every cycle; the pop state consumes it
   ssa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (head_ff),
      .rd_data (mem_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !hold_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;

   // growth fits only if a whole chunk stays within the pool
   assign grow_sum  = SUM_W'(cap_ff) + SUM_W'(cfg.chunk);
   assign grow_oom  = grow_sum > SUM_W'(MAX_SLOTS);
   assign not_owned = CMP_W'(req_ch.slot_index) >= CMP_W'(cap_ff);

   // chunk links: lowest new slot ends the list, the others point one below
   assign grow_link = (wr_ptr_ff == SLOT_W'(cap_ff)) ? '0 : wr_ptr_ff - SLOT_W'(1);

   // one shared multiplier for the byte offset, registered in the result buffer
   assign mul_a = (state_ff == S_GROW) ? top_ff : head_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(cfg.stride);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      len_in    = len_ff;
      cap_in    = cap_ff;
      live_in   = live_ff;
      wr_ptr_in = wr_ptr_ff;
      top_in    = top_ff;
      mem_we    = 1'b0;
      mem_waddr = wr_ptr_ff;
      mem_wdata = grow_link;
      res_fire  = 1'b0;
      res.slot        = '0;
      res.byte_offset = '0;
      res.status      = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_ch.command))
                  CMD_ALLOC: begin
                     if (len_ff != '0) begin
                        state_in = S_POP;
                     end else if (grow_oom) begin
                        res_fire   = 1'b1;
                        res.status = ST_OOM;
                     end else begin
                        state_in  = S_GROW;
                        wr_ptr_in = SLOT_W'(cap_ff);
                        top_in    = SLOT_W'(grow_sum - SUM_W'(1));
                     end
                  end
                  CMD_FREE: begin
                     res_fire = 1'b1;
                     if (!req_ch.is_null) begin
                        if (not_owned) begin
                           res.status = ST_NOT_OWNED;
                        end else begin
                           // push: link to the old head, or end of list if empty
                           mem_we    = 1'b1;
                           mem_waddr = SLOT_W'(req_ch.slot_index);
                           mem_wdata = (len_ff != '0) ? head_ff : '0;
                           head_in   = SLOT_W'(req_ch.slot_index);
                           if (len_ff != CNT_W'(MAX_SLOTS)) begin
                              len_in = len_ff + CNT_W'(1);
                           end
                           if (live_ff != '0) begin
                              live_in = live_ff - CNT_W'(1);
                           end
                        end
                     end
                  end
                  CMD_DESTROY: begin
                     res_fire = 1'b1;
                     if (live_ff != '0) begin
                        res.status = ST_DESTROYED_LIVE;
                     end
                     head_in = '0;
                     len_in  = '0;
                     cap_in  = '0;
                     live_in = '0;
                  end
                  default: begin
                     res_fire = 1'b1;
                  end
               endcase
            end
         end

         S_POP: begin
            // link of the head arrives from memory this cycle
            res_fire        = 1'b1;
            res.slot        = SLOT_IDX_W'(head_ff);
            res.byte_offset = OFFSET_W'(prod);
            head_in         = mem_rdata;
            len_in          = len_ff - CNT_W'(1);
            if (live_ff != CNT_W'(MAX_SLOTS)) begin
               live_in = live_ff + CNT_W'(1);
            end
            state_in = S_IDLE;
         end

         S_GROW: begin
            mem_we = 1'b1;
            if (wr_ptr_ff == top_ff) begin
               // last link written; pop the highest new slot straight away
               res_fire        = 1'b1;
               res.slot        = SLOT_IDX_W'(top_ff);
               res.byte_offset = OFFSET_W'(prod);
               head_in         = grow_link;
               len_in          = CNT_W'(top_ff) - cap_ff;
               cap_in          = CNT_W'(top_ff) + CNT_W'(1);
               if (live_ff != CNT_W'(MAX_SLOTS)) begin
                  live_in = live_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end else begin
               wr_ptr_in = wr_ptr_ff + SLOT_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.live_count = COUNT_W'(live_in);
      res.capacity   = COUNT_W'(cap_in);
   end

   // output register plus hold register; a new result only comes with the hold empty
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_res_in    = rsp_res_ff;
      hold_valid_in = hold_valid_ff;
      hold_res_in   = hold_res_ff;
      if (out_free) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_res_in    = hold_res_ff;
            hold_valid_in = 1'b0;
         end else if (res_fire) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = res;
         end
      end else if (res_fire) begin
         hold_valid_in = 1'b1;
         hold_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         len_ff        <= '0;
         cap_ff        <= '0;
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         len_ff        <= len_in;
         cap_ff        <= cap_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff   <= wr_ptr_in;
      top_ff      <= top_in;
      rsp_res_ff  <= rsp_res_in;
      hold_res_ff <= hold_res_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.slot        = rsp_res_ff.slot;
   assign rsp_ch.byte_offset = rsp_res_ff.byte_offset;
   assign rsp_ch.status      = rsp_res_ff.status;
   assign rsp_ch.live_count  = rsp_res_ff.live_count;
   assign rsp_ch.capacity    = rsp_res_ff.capacity;

endmodule

// File: tb/ssa_result_checker.sv
`timescale 1ns / 100ps
// response checker of the slab slot allocator: mirrors free list, pool and csr state,
// predicts one response per accepted request and compares them in order
// depends on ssa_pkg and ssa_if

module ssa_result_checker #(
   parameter int MAX_SLOTS       = 1024,
   parameter int MIN_CHUNK_SLOTS = 8,
   parameter int POINTER_BYTES   = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   ssa_req_if                          req_mon,
   ssa_rsp_if                          rsp_mon,
   ssa_csr_if                          csr_mon,
   output int                          fail_count,
   output int                          open_count,
   output logic [ssa_pkg::COUNT_W-1:0] cap_now
);
   import ssa_pkg::*;

   // mirrored csr values, raw as written
   logic [SPC_W-1:0] chunk_cfg;
   logic [ISZ_W-1:0] size_cfg;
   logic [ALG_W-1:0] align_cfg;

   // mirrored pool state
   logic [SLOT_IDX_W-1:0] link_mem [MAX_SLOTS];
   logic [SLOT_IDX_W-1:0] list_head;
   int                    list_len;
   int                    pool_cap;
   int                    live_slots;

   res_type due_results [$];

   function automatic int unsigned slot_stride();
      int unsigned lg;
      int unsigned sz;
      int unsigned mask;
      lg = 32'((align_cfg > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : align_cfg);
      sz = 32'(size_cfg);
      if (sz == 0) sz = 1;
      if (sz > 32'(MAX_ITEM_BYTES)) sz = 32'(MAX_ITEM_BYTES);
      mask = (32'd1 << lg) - 32'd1;
      sz = (sz + mask) & ~mask;
      if (sz < 32'(POINTER_BYTES)) sz = 32'(POINTER_BYTES);
      return sz;
   endfunction

   function automatic void push_slot(logic [SLOT_IDX_W-1:0] s);
      link_mem[s] = (list_len != 0) ? list_head : '0;
      list_head   = s;
      if (list_len < MAX_SLOTS) list_len++;
   endfunction

   // whole chunk or nothing
   function automatic bit add_chunk();
      int chunk;
      int i;
      chunk = (chunk_cfg < MIN_CHUNK_SLOTS) ? MIN_CHUNK_SLOTS : int'(chunk_cfg);
      if (pool_cap > MAX_SLOTS || chunk > MAX_SLOTS - pool_cap) return 1'b0;
      for (i = 0; i < chunk; i++) push_slot(SLOT_IDX_W'(pool_cap + i));
      pool_cap += chunk;
      return 1'b1;
   endfunction

   function automatic void clear_pool();
      foreach (link_mem[i]) link_mem[i] = '0;
      list_head  = '0;
      list_len   = 0;
      pool_cap   = 0;
      live_slots = 0;
   endfunction

   function automatic res_type apply_command(logic [CMD_W-1:0] cmd,
                                             logic [SLOT_IDX_W-1:0] idx, logic nul);
      res_type     r;
      int unsigned prod;
      r = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            if (list_len == 0 && !add_chunk()) begin
               r.status = ST_OOM;
            end else begin
               r.slot    = list_head;
               list_head = link_mem[r.slot];
               list_len--;
               if (live_slots < MAX_SLOTS) live_slots++;
               prod = 32'(r.slot) * slot_stride();
               r.byte_offset = prod[OFFSET_W-1:0];
            end
         end
         CMD_FREE: begin
            if (!nul) begin
               if (int'(idx) >= pool_cap) begin
                  r.status = ST_NOT_OWNED;
               end else begin
                  push_slot(idx);
                  if (live_slots > 0) live_slots--;
               end
            end
         end
         CMD_DESTROY: begin
            if (live_slots != 0) r.status = ST_DESTROYED_LIVE;
            clear_pool();
         end
         default: ;
      endcase
      r.live_count = live_slots[COUNT_W-1:0];
      r.capacity   = pool_cap[COUNT_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         chunk_cfg  = SPC_RESET;
         size_cfg   = ISZ_RESET;
         align_cfg  = ALG_RESET;
         clear_pool();
         due_results.delete();
         fail_count = 0;
      end else begin
         // a response never belongs to a request accepted at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: response with none expected, got slot %0d status %0d",
                        $time, rsp_mon.slot, rsp_mon.status);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("slot", want.slot, rsp_mon.slot);
               check_field("byte_offset", want.byte_offset, rsp_mon.byte_offset);
               check_field("status", want.status, rsp_mon.status);
               check_field("live_count", want.live_count, rsp_mon.live_count);
               check_field("capacity", want.capacity, rsp_mon.capacity);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_SLOTS_PER_CHUNK: chunk_cfg = csr_mon.data[SPC_W-1:0];
               CSR_ITEM_SIZE:       size_cfg  = csr_mon.data[ISZ_W-1:0];
               CSR_ALIGN_LOG2:      align_cfg = csr_mon.data[ALG_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            due_results.push_back(apply_command(req_mon.command, req_mon.slot_index,
                                                req_mon.is_null));
      end
      open_count = due_results.size();
      cap_now    = pool_cap[COUNT_W-1:0];
   end

endmodule

// File: tb/slab_slot_allocator_tb.sv
`timescale 1ns / 100ps
// testbench top of the slab slot allocator: clock, reset, request and csr stimulus,
// response back-pressure, watchdog and verdict; checking sits in ssa_result_checker
// depends on ssa_pkg, ssa_if, slab_slot_allocator and ssa_result_checker

module slab_slot_allocator_tb;
   import ssa_pkg::*;

   // the fourth command code has no name in the package
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // the quiet limit outlasts a growth of 1024 slots
   localparam int QUIET_LIMIT   = 6000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 128;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;

   ssa_req_if req_ch ();
   ssa_rsp_if rsp_ch ();
   ssa_csr_if csr_ch ();

   int               fail_count;
   int               open_count;
   logic [COUNT_W-1:0] cap_now;

   // idling percentages for the current phase
   int send_idle_pct;
   int recv_stall_pct;

   int sent_items;
   int seen_results;
   int phase_cnt;

   slab_slot_allocator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ssa_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .open_count (open_count),
      .cap_now    (cap_now)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response back-pressure, redrawn on every falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog: any transaction on any channel restarts the count
   initial begin : watchdog
      int quiet;
      quiet        = 0;
      seen_results = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) seen_results++;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // idling modes: none, sender idle, receiver stalling, both lightly
   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 75;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 75;
         end
         default: begin
            send_idle_pct  = 25;
            recv_stall_pct = 25;
         end
      endcase
   endtask

   // entered and left at a falling edge; valid stays high into the next transaction
   task automatic put_req(logic [CMD_W-1:0] cmd, logic [SLOT_IDX_W-1:0] idx, logic nul);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.slot_index <= idx;
      req_ch.is_null    <= nul;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      sent_items++;
   endtask

   // sender pauses until every outstanding response has been taken
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (open_count != 0);
   endtask

   // writes all three registers back to back, only while the block is idle
   task automatic write_cfg(logic [CSR_DATA_W-1:0] spc, logic [CSR_DATA_W-1:0] isz,
                            logic [CSR_DATA_W-1:0] alg);
      csr_idx_type           regs [3];
      logic [CSR_DATA_W-1:0] vals [3];
      regs[0] = CSR_SLOTS_PER_CHUNK;
      regs[1] = CSR_ITEM_SIZE;
      regs[2] = CSR_ALIGN_LOG2;
      vals[0] = spc;
      vals[1] = isz;
      vals[2] = alg;
      foreach (regs[i]) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= regs[i];
         csr_ch.data  <= vals[i];
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         @(negedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // mostly alloc and in-pool frees so the free list gets deep and reordered;
   // the rest is frees of random indices, null frees, destroys and the unused code
   task automatic random_item();
      int                    pick;
      logic [SLOT_IDX_W-1:0] idx;
      logic                  nul;
      pick = $urandom_range(0, 99);
      idx  = SLOT_IDX_W'($urandom_range(0, 1023));
      nul  = 1'($urandom_range(0, 1));
      if (pick < 50) begin
         put_req(CMD_ALLOC, idx, nul);
      end else if (pick < 83) begin
         if (cap_now != 0) idx = SLOT_IDX_W'($urandom_range(0, cap_now - 1));
         put_req(CMD_FREE, idx, 1'b0);
      end else if (pick < 92) begin
         put_req(CMD_FREE, idx, 1'b0);
      end else if (pick < 96) begin
         put_req(CMD_FREE, idx, 1'b1);
      end else if (pick < 98) begin
         put_req(CMD_DESTROY, idx, nul);
      end else begin
         put_req(CMD_UNUSED, idx, nul);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] spc;
      logic [CSR_DATA_W-1:0] isz;
      logic [CSR_DATA_W-1:0] alg;
      int                    p;
      int                    n;

      // every input known from the first instant
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_ALLOC;
      req_ch.slot_index = '0;
      req_ch.is_null    = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_SLOTS_PER_CHUNK;
      csr_ch.data       = '0;
      sent_items        = 0;
      phase_cnt         = 0;
      set_idling(0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening with reset settings: chunk 64, stride 16
      put_req(CMD_FREE, 10'h3FF, 1'b1);     // null handle, no change
      put_req(CMD_FREE, 10'd0, 1'b0);       // nothing owned yet
      put_req(CMD_UNUSED, 10'h2AA, 1'b1);   // unused code reports counts
      put_req(CMD_ALLOC, 10'h155, 1'b1);    // first growth, highest new slot first
      put_req(CMD_ALLOC, 10'd0, 1'b0);
      put_req(CMD_FREE, 10'd63, 1'b0);
      put_req(CMD_FREE, 10'h3FF, 1'b0);     // beyond capacity
      put_req(CMD_FREE, 10'd5, 1'b0);       // slot not live, pushed anyway
      put_req(CMD_ALLOC, 10'd0, 1'b0);      // last freed comes back first
      put_req(CMD_ALLOC, 10'd0, 1'b0);
      put_req(CMD_DESTROY, 10'd0, 1'b0);    // live slots left behind
      put_req(CMD_DESTROY, 10'h3FF, 1'b1);  // empty pool

      // largest chunk and stride: slot 1023 lands on the top byte offset
      drain();
      write_cfg(13'd1024, 13'd4096, 13'd12);
      put_req(CMD_ALLOC, 10'd0, 1'b0);
      put_req(CMD_FREE, 10'd1023, 1'b0);    // list back to full
      put_req(CMD_FREE, 10'd0, 1'b0);       // list length and live count both saturate
      put_req(CMD_ALLOC, 10'd0, 1'b0);
      put_req(CMD_DESTROY, 10'd0, 1'b0);

      // chunk can never fit: out of memory on an empty pool
      drain();
      write_cfg(13'd2047, 13'd0, 13'd0);
      put_req(CMD_ALLOC, 10'd0, 1'b0);

      // chunk raised to the minimum, oversize item and alignment clamped
      drain();
      write_cfg(13'd0, 13'h1FFF, 13'd15);
      repeat (8) put_req(CMD_ALLOC, 10'd0, 1'b0);

      // list empty and the next chunk would overrun the pool: no partial chunk
      drain();
      write_cfg(13'd1017, 13'h1FFF, 13'd15);
      put_req(CMD_ALLOC, 10'd0, 1'b0);

      // random phases, each with its own settings and idling mode
      for (p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            4:       spc = 13'd1024;
            9:       spc = CSR_DATA_W'($urandom_range(1025, 2047));   // growth always fails
            default: spc = CSR_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 16)
                                                             : $urandom_range(17, 96));
         endcase
         isz = CSR_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 8191)
                                                : $urandom_range(1, 64));
         alg = CSR_DATA_W'($urandom_range(0, 15));
         write_cfg(spc, isz, alg);
         set_idling(p % 4);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // halfway through, hold off until every response is back
            if (n == PHASE_ITEMS / 2) drain();
            random_item();
         end
         phase_cnt++;
      end

      // let the last responses out, then a short quiet spell
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d requests: a directed opening and %0d random settings phases",
               sent_items, phase_cnt);
      $display("%0d responses compared in order, %0d field mismatches",
               seen_results, fail_count);
      if (fail_count == 0 && open_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
